@@ rtl/core/rtp_pkg.sv @@
// Package for the RFC 3339 timestamp parser: queue and length settings, the queue record,
// calendar constants and the two lookup tables. Depends on nothing.
`default_nettype none

package rtp_pkg;

	// Entries in the queue between the byte parser and the arithmetic pipeline.
	localparam int QUEUE_DEPTH = 4;

	// Texts shorter than this are rejected.
	localparam int MIN_TEXT_LEN = 20;

	// Floor division by 100 through a reciprocal; exact for all 14-bit years.
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;

	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int MINS_PER_HOUR = 60;

	// Days from the start of year 0 to the start of 1970.
	localparam int EPOCH_YEAR = 1970;
	localparam int EPOCH_DAYS = 365 * EPOCH_YEAR + (EPOCH_YEAR + 3) / 4
		- (EPOCH_YEAR + 99) / 100 + (EPOCH_YEAR + 399) / 400;

	typedef struct packed {
		logic        parse_status;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [29:0] fraction;
		logic [3:0]  fraction_count;
		logic        offset_negative;
		logic [6:0]  offset_hours;
		logic [6:0]  offset_mins;
	} rtp_rec_t;

	// Days before the first of a month; months above 12 count the whole year.
	function automatic logic [8:0] days_before_month(input logic [6:0] month);
		logic [8:0] d;
		case (month)
			7'd0, 7'd1: d = 9'd0;
			7'd2:  d = 9'd31;
			7'd3:  d = 9'd59;
			7'd4:  d = 9'd90;
			7'd5:  d = 9'd120;
			7'd6:  d = 9'd151;
			7'd7:  d = 9'd181;
			7'd8:  d = 9'd212;
			7'd9:  d = 9'd243;
			7'd10: d = 9'd273;
			7'd11: d = 9'd304;
			7'd12: d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

	// Scale that right-pads a fraction of the given digit count to nanoseconds.
	function automatic logic [29:0] pad_scale(input logic [3:0] count);
		logic [29:0] s;
		case (count)
			4'd0: s = 30'd1000000000;
			4'd1: s = 30'd100000000;
			4'd2: s = 30'd10000000;
			4'd3: s = 30'd1000000;
			4'd4: s = 30'd100000;
			4'd5: s = 30'd10000;
			4'd6: s = 30'd1000;
			4'd7: s = 30'd100;
			4'd8: s = 30'd10;
			default: s = 30'd1;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rtp_if.sv @@
// Stream interfaces of the timestamp parser: the text byte channel and the
// result channel, each with valid, ready and named payload fields. No dependencies.
`default_nettype none

interface rtp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, text_byte, end_of_text, input ready);
	modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface rtp_result_if;
	logic               valid;
	logic               ready;
	logic               parse_status;
	logic signed [38:0] epoch_seconds;
	logic        [29:0] nanoseconds;
	logic signed [13:0] offset_minutes;

	modport source(output valid, parse_status, epoch_seconds, nanoseconds, offset_minutes,
		input ready);
	modport sink(input valid, parse_status, epoch_seconds, nanoseconds, offset_minutes,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/rtp_queue.sv @@
// Short FIFO of parsed timestamp records between the byte parser and the
// arithmetic pipeline. Depends on rtp_pkg.
`default_nettype none

module rtp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rtp_pkg::rtp_rec_t push_rec,
	output logic                   full,
	input  wire logic              pop,
	output rtp_pkg::rtp_rec_t      head_rec,
	output logic                   empty
);

	localparam int DEPTH = rtp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtp_pkg::rtp_rec_t entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rtp_front.sv @@
// Byte parser: takes one text byte per transfer, tracks the position in the
// timestamp form and pushes one record per timestamp. Depends on rtp_pkg, rtp_if.
`default_nettype none

module rtp_front #(
	parameter int FRACTION_DIGITS = 9
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	rtp_text_if.sink          text,
	input  wire logic         queue_full,
	output logic              push,
	output rtp_pkg::rtp_rec_t rec
);

	localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
	localparam int ACC_W  = FRAC_W + 4;
	localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);

	localparam logic [4:0] PH_SEP_YM    = 5'd4;
	localparam logic [4:0] PH_SEP_MD    = 5'd7;
	localparam logic [4:0] PH_SEP_DT    = 5'd10;
	localparam logic [4:0] PH_SEP_HM    = 5'd13;
	localparam logic [4:0] PH_SEP_MS    = 5'd16;
	localparam logic [4:0] PH_AFTER_SEC = 5'd19;
	localparam logic [4:0] PH_FRAC      = 5'd20;
	localparam logic [4:0] PH_OFF_H1    = 5'd21;
	localparam logic [4:0] PH_OFF_H2    = 5'd22;
	localparam logic [4:0] PH_OFF_COLON = 5'd23;
	localparam logic [4:0] PH_OFF_M1    = 5'd24;
	localparam logic [4:0] PH_OFF_M2    = 5'd25;
	localparam logic [4:0] PH_DONE      = 5'd26;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	logic [5:0]        pos_q, pos_d;
	logic [4:0]        phase_q, phase_d;
	logic              err_q, err_d;
	logic [13:0]       year_q, year_d;
	logic [6:0]        month_q, month_d;
	logic [6:0]        day_q, day_d;
	logic [6:0]        hour_q, hour_d;
	logic [6:0]        minute_q, minute_d;
	logic [6:0]        second_q, second_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              neg_q, neg_d;
	logic [6:0]        offh_q, offh_d;
	logic [6:0]        offm_q, offm_d;

	logic       accept;
	logic       is_digit;
	logic [3:0] digit;
	logic       is_sep;
	logic [7:0] sep_char;
	logic [7:0] c;

	assign c          = text.text_byte;
	assign text.ready = !queue_full;
	assign accept     = text.valid && text.ready;
	assign push       = accept && text.end_of_text;

	assign is_digit = (c >= 8'h30) && (c <= 8'h39);
	assign digit    = is_digit ? c[3:0] : 4'd0;
	assign is_sep   = (phase_q == PH_SEP_YM) || (phase_q == PH_SEP_MD) ||
		(phase_q == PH_SEP_DT) || (phase_q == PH_SEP_HM) || (phase_q == PH_SEP_MS);
	assign sep_char = (phase_q == PH_SEP_DT) ? CH_T :
		((phase_q == PH_SEP_HM || phase_q == PH_SEP_MS) ? CH_COLON : CH_DASH);

	always_comb begin
		pos_d    = (pos_q == 6'd63) ? pos_q : pos_q + 6'd1;
		phase_d  = phase_q;
		err_d    = err_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		frac_d   = frac_q;
		cnt_d    = cnt_q;
		neg_d    = neg_q;
		offh_d   = offh_q;
		offm_d   = offm_q;
		// Once an error is seen, later bytes change nothing but the byte position until the final one.
		if (!err_q) begin
			if (phase_q < PH_AFTER_SEC) begin
				if (is_sep) begin
					if (c != sep_char) begin
						err_d = 1'b1;
					end else begin
						phase_d = phase_q + 5'd1;
					end
				end else if (!is_digit) begin
					err_d = 1'b1;
				end else begin
					phase_d = phase_q + 5'd1;
					if (phase_q < PH_SEP_YM) begin
						year_d = year_q * 14'd10 + 14'(digit);
					end else if (phase_q < PH_SEP_MD) begin
						month_d = month_q * 7'd10 + 7'(digit);
					end else if (phase_q < PH_SEP_DT) begin
						day_d = day_q * 7'd10 + 7'(digit);
					end else if (phase_q < PH_SEP_HM) begin
						hour_d = hour_q * 7'd10 + 7'(digit);
					end else if (phase_q < PH_SEP_MS) begin
						minute_d = minute_q * 7'd10 + 7'(digit);
					end else begin
						second_d = second_q * 7'd10 + 7'(digit);
					end
				end
			end else begin
				case (phase_q)
					PH_AFTER_SEC, PH_FRAC: begin
						if (phase_q == PH_AFTER_SEC && c == CH_DOT) begin
							phase_d = PH_FRAC;
						end else if (phase_q == PH_FRAC && is_digit &&
								cnt_q < CNT_W'(FRACTION_DIGITS)) begin
							frac_d = FRAC_W'(ACC_W'(frac_q) * ACC_W'(10) + ACC_W'(digit));
							cnt_d  = cnt_q + CNT_W'(1);
						end else if (c == CH_Z) begin
							phase_d = PH_DONE;
						end else if (c == CH_PLUS || c == CH_DASH) begin
							neg_d   = (c == CH_DASH);
							phase_d = PH_OFF_H1;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_OFF_H1, PH_OFF_H2: begin
						if (!is_digit) begin
							err_d = 1'b1;
						end else begin
							offh_d  = offh_q * 7'd10 + 7'(digit);
							phase_d = phase_q + 5'd1;
						end
					end
					PH_OFF_COLON: begin
						if (c != CH_COLON) begin
							err_d = 1'b1;
						end else begin
							phase_d = PH_OFF_M1;
						end
					end
					PH_OFF_M1, PH_OFF_M2: begin
						if (!is_digit) begin
							err_d = 1'b1;
						end else begin
							offm_d  = offm_q * 7'd10 + 7'(digit);
							phase_d = (phase_q == PH_OFF_M2) ? PH_DONE : PH_OFF_M2;
						end
					end
					default: begin
						err_d = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		rec.parse_status    = err_d || (phase_d != PH_DONE) ||
			(pos_d < 6'(rtp_pkg::MIN_TEXT_LEN));
		rec.year            = year_d;
		rec.month           = month_d;
		rec.day             = day_d;
		rec.hour            = hour_d;
		rec.minute          = minute_d;
		rec.second          = second_d;
		rec.fraction        = 30'(frac_d);
		rec.fraction_count  = 4'(cnt_d);
		rec.offset_negative = neg_d;
		rec.offset_hours    = offh_d;
		rec.offset_mins     = offm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			offh_q   <= '0;
			offm_q   <= '0;
		end else if (accept) begin
			if (text.end_of_text) begin
				// The final byte hands its record over and starts a fresh timestamp.
				pos_q    <= '0;
				phase_q  <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				frac_q   <= '0;
				cnt_q    <= '0;
				neg_q    <= 1'b0;
				offh_q   <= '0;
				offm_q   <= '0;
			end else begin
				pos_q    <= pos_d;
				phase_q  <= phase_d;
				err_q    <= err_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				frac_q   <= frac_d;
				cnt_q    <= cnt_d;
				neg_q    <= neg_d;
				offh_q   <= offh_d;
				offm_q   <= offm_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rtp_back.sv @@
// Three-stage arithmetic pipeline that turns a parsed record into Unix seconds,
// nanoseconds and the zone offset. Depends on rtp_pkg and rtp_if.
`default_nettype none

module rtp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtp_pkg::rtp_rec_t head_rec,
	input  wire logic              empty,
	output logic                   pop,
	rtp_result_if.source           result
);

	logic advance;
	logic v_s1, v_s2, v_s3;

	// Stage 1
	logic               status_s1;
	logic [13:0]        year_s1;
	logic [6:0]         q100_s1;
	logic [8:0]         dbm_s1;
	logic               late_s1;
	logic [6:0]         day_s1;
	logic [18:0]        hms_s1;
	logic signed [13:0] off_s1;
	logic [29:0]        ns_s1;

	// Stage 2
	logic               status_s2;
	logic signed [24:0] days_s2;
	logic signed [21:0] tod_s2;
	logic signed [13:0] off_s2;
	logic [29:0]        ns_s2;

	// Stage 3 is the output register
	logic               status_s3;
	logic signed [38:0] secs_s3;
	logic [29:0]        ns_s3;
	logic signed [13:0] off_s3;

	logic [25:0]        q100_prod;
	logic [12:0]        off_mag;
	logic signed [13:0] off_d;
	logic [18:0]        hms_d;
	logic [3:0]         cnt_clamped;
	logic [13:0]        rem100;
	logic               rem_nz;
	logic               leap;
	logic [12:0]        ceil4;
	logic [6:0]         ceil100;
	logic [5:0]         ceil400;
	logic [24:0]        days_pos;
	logic [24:0]        days_neg;
	logic signed [21:0] off_wide;
	logic signed [40:0] secs_full;

	assign advance = !v_s3 || result.ready;
	assign pop     = advance && !empty;

	// Stage 1: year divided by 100, month table, time of day in seconds, offset in minutes, fraction scale.
	assign q100_prod   = 26'(head_rec.year) * 26'(rtp_pkg::DIV100_MUL);
	assign off_mag     = 13'(head_rec.offset_hours) * 13'(rtp_pkg::MINS_PER_HOUR) +
		13'(head_rec.offset_mins);
	assign off_d       = head_rec.offset_negative ? -$signed({1'b0, off_mag}) :
		$signed({1'b0, off_mag});
	assign hms_d       = 19'(head_rec.hour) * 19'(rtp_pkg::SECS_PER_HOUR) +
		19'(head_rec.minute) * 19'(rtp_pkg::SECS_PER_MIN) + 19'(head_rec.second);
	assign cnt_clamped = (head_rec.fraction_count > 4'd9) ? 4'd9 : head_rec.fraction_count;

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s1 <= head_rec.parse_status;
			year_s1   <= head_rec.year;
			q100_s1   <= q100_prod[rtp_pkg::DIV100_SHIFT +: 7];
			dbm_s1    <= rtp_pkg::days_before_month(head_rec.month);
			late_s1   <= (head_rec.month >= 7'd3);
			day_s1    <= head_rec.day;
			hms_s1    <= hms_d;
			off_s1    <= off_d;
			ns_s1     <= head_rec.fraction * rtp_pkg::pad_scale(cnt_clamped);
		end
	end

	// Stage 2: day count in closed form and time of day less the offset.
	assign rem100  = year_s1 - 14'(q100_s1) * 14'd100;
	assign rem_nz  = (rem100 != 14'd0);
	assign leap    = (year_s1[1:0] == 2'd0 && rem_nz) || (!rem_nz && q100_s1[1:0] == 2'd0);
	assign ceil4   = 13'((15'(year_s1) + 15'd3) >> 2);
	assign ceil100 = q100_s1 + 7'(rem_nz);
	assign ceil400 = 6'(q100_s1 >> 2) + 6'(rem_nz || (q100_s1[1:0] != 2'd0));
	assign days_pos = 25'(year_s1) * 25'd365 + 25'(ceil4) + 25'(ceil400) + 25'(dbm_s1) +
		25'(late_s1 && leap) + 25'(day_s1);
	assign days_neg = 25'(ceil100) + 25'(rtp_pkg::EPOCH_DAYS) + 25'd1;
	assign off_wide = 22'(off_s1);

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_s1;
			days_s2   <= $signed(days_pos - days_neg);
			tod_s2    <= $signed(22'(hms_s1)) - off_wide * 22'sd60;
			off_s2    <= off_s1;
			ns_s2     <= ns_s1;
		end
	end

	// Stage 3: days to seconds; a malformed text gives zeros.
	assign secs_full = 41'(days_s2) * 41'sd86400 + 41'(tod_s2);

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s3 <= status_s2;
			secs_s3   <= status_s2 ? '0 : secs_full[38:0];
			ns_s3     <= status_s2 ? '0 : ns_s2;
			off_s3    <= status_s2 ? '0 : off_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign result.valid          = v_s3;
	assign result.parse_status   = status_s3;
	assign result.epoch_seconds  = secs_s3;
	assign result.nanoseconds    = ns_s3;
	assign result.offset_minutes = off_s3;

endmodule

`default_nettype wire

@@ rtl/core/rfc3339_timestamp_parser.sv @@
// RFC 3339 timestamp parser: one text byte per transfer, one result per timestamp.
// Throughput is one byte per cycle while the queue has room; the parser updates its
// phase on each accepted byte. A result is offered once the final byte's record passes a
// four-entry record queue and a three-stage arithmetic pipeline that stalls as a whole.
// Reset (arst_n low) clears parser state, queue pointers and pipeline valid bits at once.
`default_nettype none

module rfc3339_timestamp_parser #(
	parameter int FRACTION_DIGITS = 9
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rtp_text_if.sink     text,
	rtp_result_if.source result
);

	rtp_pkg::rtp_rec_t push_rec;
	rtp_pkg::rtp_rec_t head_rec;
	logic              push;
	logic              full;
	logic              pop;
	logic              empty;

	rtp_front #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.queue_full(full),
		.push      (push),
		.rec       (push_rec)
	);

	rtp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.full    (full),
		.pop     (pop),
		.head_rec(head_rec),
		.empty   (empty)
	);

	rtp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_rec(head_rec),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the RFC 3339 timestamp parser: sends texts a byte at a time and checks
// every result against a behavioural decoder kept in step with the accepted transfers.
// Depends on rtp_if.sv (stream interfaces) and the rfc3339_timestamp_parser RTL.

module tb_top;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic               status;
		logic signed [38:0] secs;
		logic        [29:0] nanos;
		logic signed [13:0] offset;
	} stamp_t;

	localparam int MAX_FRAC    = 9;
	localparam int MIN_LEN     = 20;
	localparam int EPOCH_YEAR  = 1970;
	localparam int DRAIN_WAIT  = 10;
	localparam int LONG_HOLD   = 400;
	localparam int RANDOM_BYTES = 200;
	localparam int RANDOM_TEXTS = 8;

	// Positions of the separators in the date and time part.
	localparam int POS_DASH1  = 4;
	localparam int POS_DASH2  = 7;
	localparam int POS_T      = 10;
	localparam int POS_COLON1 = 13;
	localparam int POS_COLON2 = 16;

	// Decoder phases after the seconds.
	localparam int PH_AFTER_SECS = 19;
	localparam int PH_FRACTION   = 20;
	localparam int PH_OFF_H1     = 21;
	localparam int PH_OFF_H2     = 22;
	localparam int PH_OFF_COLON  = 23;
	localparam int PH_OFF_M1     = 24;
	localparam int PH_OFF_M2     = 25;
	localparam int PH_COMPLETE   = 26;

	localparam logic [7:0] ASC_ZERO  = "0";
	localparam logic [7:0] ASC_NINE  = "9";
	localparam logic [7:0] ASC_DASH  = "-";
	localparam logic [7:0] ASC_PLUS  = "+";
	localparam logic [7:0] ASC_COLON = ":";
	localparam logic [7:0] ASC_DOT   = ".";
	localparam logic [7:0] ASC_T     = "T";
	localparam logic [7:0] ASC_Z     = "Z";

	localparam int MONTH_START [0:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
		334, 365};

	logic clk;
	logic arst_n;

	rtp_text_if   text_ch();
	rtp_result_if result_ch();

	rfc3339_timestamp_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	stamp_t      pending_stamps[$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b1;
	int unsigned long_hold_request = 0;

	// Decoder state.
	int unsigned pos_count;
	int unsigned text_phase;
	bit          err_flag;
	int unsigned yr, mon, dy, hh, mi, ss;
	int unsigned frac_acc, frac_cnt;
	bit          off_neg;
	int unsigned off_hh, off_mm;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_decoder();
		pos_count = 0;
		text_phase = 0;
		err_flag = 1'b0;
		yr = 0;
		mon = 0;
		dy = 0;
		hh = 0;
		mi = 0;
		ss = 0;
		frac_acc = 0;
		frac_cnt = 0;
		off_neg = 1'b0;
		off_hh = 0;
		off_mm = 0;
	endfunction

	function automatic longint days_to_year(input longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic bit is_leap(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		bit          is_digit;
		int unsigned v;
		logic [7:0]  sep;
		is_digit = (c >= ASC_ZERO) && (c <= ASC_NINE);
		v = is_digit ? int'(c - ASC_ZERO) : 0;
		if (text_phase < PH_AFTER_SECS) begin
			if (text_phase == POS_DASH1 || text_phase == POS_DASH2 || text_phase == POS_T ||
					text_phase == POS_COLON1 || text_phase == POS_COLON2) begin
				sep = (text_phase == POS_T) ? ASC_T :
					(text_phase == POS_DASH1 || text_phase == POS_DASH2) ? ASC_DASH : ASC_COLON;
				if (c != sep) begin
					err_flag = 1'b1;
					return;
				end
			end else begin
				if (!is_digit) begin
					err_flag = 1'b1;
					return;
				end
				if (text_phase < POS_DASH1) yr = yr * 10 + v;
				else if (text_phase < POS_DASH2) mon = mon * 10 + v;
				else if (text_phase < POS_T) dy = dy * 10 + v;
				else if (text_phase < POS_COLON1) hh = hh * 10 + v;
				else if (text_phase < POS_COLON2) mi = mi * 10 + v;
				else ss = ss * 10 + v;
			end
			text_phase++;
			return;
		end
		case (text_phase)
			PH_AFTER_SECS, PH_FRACTION: begin
				if (text_phase == PH_AFTER_SECS && c == ASC_DOT) begin
					text_phase = PH_FRACTION;
				end else if (text_phase == PH_FRACTION && is_digit && frac_cnt < MAX_FRAC) begin
					frac_acc = frac_acc * 10 + v;
					frac_cnt++;
				end else if (c == ASC_Z) begin
					text_phase = PH_COMPLETE;
				end else if (c == ASC_PLUS || c == ASC_DASH) begin
					off_neg = (c == ASC_DASH);
					text_phase = PH_OFF_H1;
				end else begin
					err_flag = 1'b1;
				end
			end
			PH_OFF_H1, PH_OFF_H2: begin
				if (!is_digit) err_flag = 1'b1;
				else begin
					off_hh = off_hh * 10 + v;
					text_phase++;
				end
			end
			PH_OFF_COLON: begin
				if (c != ASC_COLON) err_flag = 1'b1;
				else text_phase = PH_OFF_M1;
			end
			PH_OFF_M1, PH_OFF_M2: begin
				if (!is_digit) err_flag = 1'b1;
				else begin
					off_mm = off_mm * 10 + v;
					text_phase = (text_phase == PH_OFF_M2) ? PH_COMPLETE : PH_OFF_M2;
				end
			end
			default: err_flag = 1'b1;
		endcase
	endfunction

	function automatic stamp_t timestamp_value();
		stamp_t      r;
		longint      days, offs, secs, scale, nanos;
		int unsigned m;
		r.status = 1'b1;
		r.secs = '0;
		r.nanos = '0;
		r.offset = '0;
		if (err_flag || text_phase != PH_COMPLETE || pos_count < MIN_LEN) return r;
		m = (mon > 13) ? 13 : mon;
		days = days_to_year(longint'(yr)) - days_to_year(EPOCH_YEAR);
		if (m >= 1) days += MONTH_START[m - 1];
		if (m >= 3 && is_leap(longint'(yr))) days += 1;
		days += longint'(dy) - 1;
		offs = longint'(off_hh) * 60 + longint'(off_mm);
		if (off_neg) offs = -offs;
		secs = days * 86400 + longint'(hh) * 3600 + longint'(mi) * 60 + longint'(ss)
			- offs * 60;
		scale = 1;
		for (int i = frac_cnt; i < MAX_FRAC; i++) scale *= 10;
		nanos = longint'(frac_acc) * scale;
		r.status = 1'b0;
		r.secs = secs[38:0];
		r.nanos = nanos[29:0];
		r.offset = offs[13:0];
		return r;
	endfunction

	// Advances the decoder by one byte; returns 1 when the byte closes a timestamp.
	function automatic bit decode_byte(input logic [7:0] c, input bit last, output stamp_t r);
		if (pos_count < 63) pos_count++;
		if (!err_flag) parse_char(c);
		if (!last) return 1'b0;
		r = timestamp_value();
		clear_decoder();
		return 1'b1;
	endfunction

	function automatic void put_num(inout byte_q_t q, input int unsigned v, input int digits);
		int unsigned div;
		div = 1;
		repeat (digits - 1) div *= 10;
		repeat (digits) begin
			q.push_back(8'(ASC_ZERO + (v / div) % 10));
			div /= 10;
		end
	endfunction

	// Builds a text, well-formed up to 9 fraction digits; a length below 0 omits the dot.
	function automatic byte_q_t make_stamp(input int frac_len);
		byte_q_t q;
		bit      wide;
		wide = ($urandom_range(0, 7) == 0);
		case ($urandom_range(0, 3))
			0: put_num(q, $urandom_range(0, 9999), 4);
			1: put_num(q, $urandom_range(0, 99), 4);
			2: put_num(q, $urandom_range(9900, 9999), 4);
			default: put_num(q, $urandom_range(1900, 2100), 4);
		endcase
		q.push_back(ASC_DASH);
		put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
		q.push_back(ASC_DASH);
		put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(1, 31), 2);
		q.push_back(ASC_T);
		put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
		q.push_back(ASC_COLON);
		put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
		q.push_back(ASC_COLON);
		put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(0, 60), 2);
		if (frac_len >= 0) begin
			q.push_back(ASC_DOT);
			repeat (frac_len) q.push_back(8'(ASC_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 2) == 0) begin
			q.push_back(ASC_Z);
		end else begin
			q.push_back($urandom_range(0, 1) ? ASC_PLUS : ASC_DASH);
			put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(0, 14), 2);
			q.push_back(ASC_COLON);
			put_num(q, wide ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
		end
		return q;
	endfunction

	function automatic byte_q_t random_text();
		byte_q_t     q;
		int unsigned pick, n, at;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return make_stamp($urandom_range(0, 1) ? int'($urandom_range(0, 9)) : -1);
		if (pick == 9) begin
			n = $urandom_range(1, 40);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		q = make_stamp($urandom_range(0, 9));
		case ($urandom_range(0, 3))
			0: begin
				at = $urandom_range(0, q.size() - 1);
				q[at] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
					8'(ASC_ZERO + $urandom_range(0, 9));
			end
			1: q = q[0:$urandom_range(0, q.size() - 2)];
			2: begin
				n = $urandom_range(1, 5);
				repeat (n) q.push_back(8'($urandom_range(0, 255)));
			end
			default: q = make_stamp($urandom_range(10, 12));
		endcase
		return q;
	endfunction

	// Offers one byte and waits for its transfer; sends in bursts, with gaps if gaps_on.
	task automatic send_byte(input logic [7:0] b, input bit last);
		stamp_t      r;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(1, 8) : 0;
			if (gap != 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_text <= last;
		@(posedge clk);
		while (text_ch.ready !== 1'b1) @(posedge clk);
		if (decode_byte(b, last, r)) pending_stamps.push_back(r);
		@(negedge clk);
	endtask

	task automatic send_text(input byte_q_t q);
		foreach (q[i]) send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic send_string(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		send_text(q);
	endtask

	// The sender stays idle until every result has been taken and the drain wait is over.
	task automatic wait_for_results();
		text_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_stamps.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic test_valid_forms();
		send_string("1970-01-01T00:00:00Z");
		send_string("0000-01-01T00:00:00Z");
		send_string("9999-12-31T23:59:59.999999999Z");
		send_string("2000-02-29T12:00:00.5+05:30");
		send_string("1900-03-01T00:00:00Z");
		send_string("2021-06-15T08:30:00.-00:00");
		send_string("1969-12-31T23:59:59.123456-08:00");
	endtask

	task automatic test_out_of_range_fields();
		send_string("9999-99-99T99:99:99.999999999-99:99");
		send_string("0000-00-00T00:00:00+99:99");
		send_string("2024-13-05T10:00:00Z");
		send_string("2023-05-00T10:00:00Z");
		send_string("2024-02-30T24:60:61+00:99");
	endtask

	task automatic test_malformed_forms();
		send_string("2021-06-15T08:30:00.1234567890Z");
		send_string("2021-06-15T08:30:00ZX");
		send_string("2021-06-15T08:30:00+01:00Z");
		send_string("2021-06-15T08:30");
		send_string("X");
		send_string("2021/06-15T08:30:00Z");
		send_string("2021-06-15t08:30:00Z");
		send_string("2021-06-15T08:30:00+0100");
		send_string("2021-06-15T08:30:00+01:0");
		send_string("2021-06-15T08:30:0AZ");
		send_string("2021-06-15T08:30:00");
		send_string("2021-06-15T08:30:00..5Z");
		send_string("2021-06-15T08:30:00\377");
		// Long enough for the byte counter to saturate.
		send_string({"1970-01-01T00:00:00Z", "000000000000000000000000000000000000000000000"});
	endtask

	// The receiver holds off while the sender keeps offering, so the block fills and
	// stops accepting transfers.
	task automatic test_back_pressure();
		gaps_on = 1'b0;
		@(posedge clk);
		long_hold_request = LONG_HOLD;
		@(negedge clk);
		repeat (12) send_string("?");
		repeat (4) send_text(make_stamp(3));
		gaps_on = 1'b1;
	endtask

	task automatic test_random_texts();
		byte_q_t     txt;
		int unsigned bytes_sent, texts_sent;
		bytes_sent = 0;
		texts_sent = 0;
		while (bytes_sent < RANDOM_BYTES || texts_sent < RANDOM_TEXTS) begin
			if (texts_sent % 16 == 0) gaps_on = ($urandom_range(0, 3) != 0);
			txt = random_text();
			send_text(txt);
			bytes_sent += txt.size();
			texts_sent++;
		end
	endtask

	// Result side: a long hold on request, otherwise a rotating stall pattern.
	initial begin : result_receiver
		int unsigned hold_left, idx, span;
		logic [15:0] pattern;
		result_ch.ready = 1'b0;
		hold_left = 0;
		idx = 0;
		span = 0;
		pattern = '1;
		forever begin
			@(negedge clk);
			if (long_hold_request != 0) begin
				hold_left = long_hold_request;
				long_hold_request = 0;
			end
			if (span == 0) begin
				span = $urandom_range(50, 300);
				case ($urandom_range(0, 3))
					0: pattern = '1;
					1: pattern = 16'($urandom);
					default: pattern = 16'($urandom | $urandom);
				endcase
				pattern[$urandom_range(0, 15)] = 1'b1;
			end
			span--;
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= pattern[idx];
			end
			idx = (idx + 1) % 16;
		end
	end

	always @(posedge clk) begin : result_check
		stamp_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_stamps.size() == 0) begin
				$error("result transfer with no timestamp outstanding");
				fail_count++;
			end else begin
				want = pending_stamps.pop_front();
				if (result_ch.parse_status !== want.status) begin
					$error("parse_status: expected %0d, got %0d", want.status,
						result_ch.parse_status);
					fail_count++;
				end
				if (result_ch.epoch_seconds !== want.secs) begin
					$error("epoch_seconds: expected %0d, got %0d", want.secs,
						result_ch.epoch_seconds);
					fail_count++;
				end
				if (result_ch.nanoseconds !== want.nanos) begin
					$error("nanoseconds: expected %0d, got %0d", want.nanos,
						result_ch.nanoseconds);
					fail_count++;
				end
				if (result_ch.offset_minutes !== want.offset) begin
					$error("offset_minutes: expected %0d, got %0d", want.offset,
						result_ch.offset_minutes);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.end_of_text = 1'b0;
		clear_decoder();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_valid_forms();
		test_out_of_range_fields();
		test_malformed_forms();
		wait_for_results();
		test_back_pressure();
		wait_for_results();
		test_random_texts();
		wait_for_results();
		if (fail_count == 0 && pending_stamps.size() == 0)
			$display("rfc3339_timestamp_parser test passed");
		else
			$display("rfc3339_timestamp_parser test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("rfc3339_timestamp_parser test failed");
		$finish;
	end

endmodule
